/* hdl/unsigned_to_radix_ascii_top_defines.svh */
// Assertion macros for the radix ASCII converter datapath.
`ifndef UNSIGNED_TO_RADIX_ASCII_TOP_DEFINES_SVH
`define UNSIGNED_TO_RADIX_ASCII_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk_i, off during reset.
`define U2RA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk_i, off during reset.
`define U2RA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define U2RA_ASSERT_IMP(lbl, ante, cons, msg)
`define U2RA_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* hdl/u2ra_pkg.sv */
// Shared constants and controller/datapath interface types.
package u2ra_pkg;

  localparam int unsigned DIGIT_DEPTH = 64;
  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned RADIX_W     = 6;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned DIGIT_W     = 6;
  localparam int unsigned IN_W        = VALUE_W + RADIX_W;
  localparam int unsigned IN_TDATA_W  = ((IN_W + 7) / 8) * 8;

  typedef struct packed {
    logic load;      // take value and radix from the input transaction
    logic div_step;  // one chunk of the long division
    logic rd_issue;  // read next digit, most significant first
    logic out_char;  // load output register with a digit character
    logic out_err;   // load output register with the error result
  } u2ra_cmd_t;

  typedef struct packed {
    logic radix_bad;   // input radix outside 2..36
    logic div_done;    // last digit written this cycle
    logic count_zero;  // digit pointer reached the least significant digit
    logic out_free;    // output register can take a new result
  } u2ra_sts_t;

endpackage

/* hdl/unsigned_to_radix_ascii_top.sv */
// Each digit takes a long division pass over the value at 8 quotient bits per cycle; the digits
// are then read back and characters leave at one per cycle while the output is not stalled.
// A new transaction is taken only once the last character is loaded into the output register.
// A result has up to 64 digits (base 2). A stalled output holds the emitter until it drains.
// A bad radix gives its single result via the error state once the output register is free.
// Reset (rst_ni, async, active low) clears sequencer, counters and output valid, not the store.
module unsigned_to_radix_ascii_top #(
  parameter int unsigned DigitDepth = u2ra_pkg::DIGIT_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [u2ra_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [63:0] value, [69:64] radix
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [u2ra_pkg::CHAR_W-1:0]       m_axis_tdata,  // [7:0] digit_char
  output logic                              m_axis_tlast,
  output logic                              m_axis_tuser   // [0] bad_radix
);

  u2ra_pkg::u2ra_cmd_t cmd;
  u2ra_pkg::u2ra_sts_t sts;

  u2ra_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_ready_o(s_axis_tready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  u2ra_dp #(
    .DigitDepth(DigitDepth)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata[u2ra_pkg::IN_W-1:0]),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_char_o (m_axis_tdata),
    .out_last_o (m_axis_tlast),
    .out_bad_o  (m_axis_tuser)
  );

endmodule

/* hdl/u2ra_ram.sv */
// Generic single write port RAM with registered read.
module u2ra_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/u2ra_ctrl.sv */
// Conversion sequencer: divide, then read digits back and emit them; a bad radix emits an error result.
module u2ra_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  u2ra_pkg::u2ra_sts_t sts_i,
  output u2ra_pkg::u2ra_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_RD   = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_ERR  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          if (sts_i.radix_bad) begin
            state_d = ST_ERR;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_char = 1'b1;
          if (sts_i.count_zero) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.rd_issue = 1'b1;
          end
        end
      end
      ST_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.out_err = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/u2ra_dp.sv */
// Datapath: chunked long division, digit store, output register.
`include "unsigned_to_radix_ascii_top_defines.svh"

module u2ra_dp #(
  parameter int unsigned DigitDepth = u2ra_pkg::DIGIT_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [u2ra_pkg::IN_W-1:0]        in_data_i,
  input  u2ra_pkg::u2ra_cmd_t              cmd_i,
  output u2ra_pkg::u2ra_sts_t              sts_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [u2ra_pkg::CHAR_W-1:0]      out_char_o,
  output logic                             out_last_o,
  output logic                             out_bad_o
);

  localparam int unsigned ValueW  = u2ra_pkg::VALUE_W;
  localparam int unsigned RadixW  = u2ra_pkg::RADIX_W;
  localparam int unsigned DigitW  = u2ra_pkg::DIGIT_W;
  localparam int unsigned CharW   = u2ra_pkg::CHAR_W;
  localparam int unsigned DivBits = 8;
  localparam int unsigned Chunks  = ValueW / DivBits;
  localparam int unsigned ChunkW  = $clog2(Chunks);
  localparam int unsigned AddrW   = $clog2(DigitDepth);
  localparam int unsigned CntW    = AddrW + 1;

  localparam logic [RadixW-1:0] RadixMin  = RadixW'(2);
  localparam logic [RadixW-1:0] RadixMax  = RadixW'(36);
  localparam logic [DigitW-1:0] DecLimit  = DigitW'(10);
  localparam logic [CharW-1:0]  AsciiZero = CharW'(8'h30);
  localparam logic [CharW-1:0]  AsciiAlpha = CharW'(8'h41 - 10);

  function automatic logic [CharW-1:0] digit_to_ascii(input logic [DigitW-1:0] d);
    logic [CharW-1:0] base;
    base = (d < DecLimit) ? AsciiZero : AsciiAlpha;
    return base + CharW'(d);
  endfunction

  logic [ValueW-1:0] quot_q, quot_d;
  logic [DigitW-1:0] rem_q, rem_d;
  logic [RadixW-1:0] radix_q;
  logic [ChunkW-1:0] chunk_q;
  logic [CntW-1:0]   count_q;
  logic              digit_end;
  logic              digit_we;
  logic [DigitW-1:0] rd_digit;
  logic [AddrW-1:0]  raddr;

  logic              out_valid_q;
  logic [CharW-1:0]  out_char_q;
  logic              out_last_q;
  logic              out_bad_q;
  logic              out_free;
  logic              radix_bad;
  logic [RadixW-1:0] in_radix;

  assign in_radix = in_data_i[ValueW +: RadixW];

  always_comb begin
    radix_bad = !(in_radix inside {[RadixMin:RadixMax]});
  end

  // Long division of the top DivBits of the running quotient per cycle.
  always_comb begin : div_chunk
    logic [DigitW:0]    acc;
    logic [DigitW-1:0]  r;
    logic [DivBits-1:0] bits;
    logic [DivBits-1:0] qbits;
    r     = rem_q;
    bits  = quot_q[ValueW-1 -: DivBits];
    qbits = '0;
    for (int i = DivBits - 1; i >= 0; i--) begin
      acc = {r, bits[i]};
      if (acc >= {1'b0, radix_q}) begin
        acc      = acc - {1'b0, radix_q};
        qbits[i] = 1'b1;
      end
      r = acc[DigitW-1:0];
    end
    rem_d  = r;
    quot_d = {quot_q[ValueW-DivBits-1:0], qbits};
  end

  assign digit_end = (chunk_q == ChunkW'(Chunks - 1));
  assign digit_we  = cmd_i.div_step && digit_end;
  assign raddr     = AddrW'(count_q - CntW'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      quot_q  <= in_data_i[ValueW-1:0];
      rem_q   <= '0;
      radix_q <= in_radix;
    end else if (cmd_i.div_step) begin
      quot_q <= quot_d;
      rem_q  <= digit_end ? '0 : rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= '0;
      count_q <= '0;
    end else if (cmd_i.load) begin
      chunk_q <= '0;
      count_q <= '0;
    end else begin
      if (cmd_i.div_step) begin
        chunk_q <= chunk_q + ChunkW'(1);
      end
      if (digit_we) begin
        count_q <= count_q + CntW'(1);
      end else if (cmd_i.rd_issue) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  u2ra_ram #(
    .Width(DigitW),
    .Depth(DigitDepth)
  ) u_digits (
    .clk_i  (clk_i),
    .we_i   (digit_we),
    .waddr_i(count_q[AddrW-1:0]),
    .wdata_i(rem_d),
    .re_i   (cmd_i.rd_issue),
    .raddr_i(raddr),
    .rdata_o(rd_digit)
  );

  // Output register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_char || cmd_i.out_err) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_char) begin
      out_char_q <= digit_to_ascii(rd_digit);
      out_last_q <= (count_q == '0);
      out_bad_q  <= 1'b0;
    end else if (cmd_i.out_err) begin
      out_char_q <= '0;
      out_last_q <= 1'b1;
      out_bad_q  <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;
  assign out_bad_o   = out_bad_q;

  assign sts_o.radix_bad  = radix_bad;
  assign sts_o.div_done   = digit_we &&
                            ((quot_d == '0) || (count_q == CntW'(DigitDepth - 1)));
  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.out_free   = out_free;

  `U2RA_ASSERT_IMP(a_out_load_free, cmd_i.out_char || cmd_i.out_err, out_free,
                   "output register loaded while a result is stalled")
  `U2RA_ASSERT_IMP(a_digit_in_range, digit_we, count_q < CntW'(DigitDepth),
                   "digit written beyond the store")
  `U2RA_ASSERT_IMP(a_read_nonempty, cmd_i.rd_issue, count_q != '0,
                   "digit read with no digit left")
  `U2RA_ASSERT_NXT(a_last_flag, cmd_i.out_char && (count_q == '0),
                   out_valid_q && out_last_q && !out_bad_q,
                   "final character not flagged last")

endmodule

/* tb/unsigned_to_radix_ascii_top_tb.sv */
// Testbench for the radix ASCII converter: table-driven and random conversions checked per character.
`timescale 1ns / 1ps

module unsigned_to_radix_ascii_top_tb;

  localparam int unsigned RANDOM_ITEMS = 200;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned TXT_BYTES    = 20;
  localparam logic [7:0]  ASCII_ZERO   = 8'h30;
  localparam logic [7:0]  ASCII_A      = 8'h41;
  localparam logic [5:0]  RADIX_LO     = 6'd2;
  localparam logic [5:0]  RADIX_HI     = 6'd36;
  localparam logic [5:0]  DECIMAL_TOP  = 6'd10;
  localparam logic [63:0] ALL_ONES     = {64{1'b1}};

  // how the expected characters of a table row are obtained
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_TEXT,
    ROW_BAD
  } row_kind_e;

  typedef struct packed {
    row_kind_e                 kind;
    logic [63:0]               value;
    logic [5:0]                radix;
    logic [8*TXT_BYTES-1:0]    txt;
  } conv_row_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       bad;
  } char_result_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [u2ra_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;  // [63:0] value, [69:64] radix
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [u2ra_pkg::CHAR_W-1:0]     m_axis_tdata;        // [7:0] digit_char
  logic                            m_axis_tlast;
  logic                            m_axis_tuser;        // [0] bad_radix

  char_result_t   char_q [$];
  char_result_t   head_r;
  int unsigned    mismatch_cnt = 0;
  int unsigned    cycle_cnt = 0;
  int unsigned    ready_hold = 0;
  logic           tail_phase = 1'b0;

  conv_row_t dir_rows [24] = '{
    '{ROW_TEXT,    64'd0,                  6'd10, "0"},
    '{ROW_TEXT,    64'd0,                  6'd2,  "0"},
    '{ROW_TEXT,    64'd0,                  6'd36, "0"},
    '{ROW_TEXT,    ALL_ONES,               6'd16, "FFFFFFFFFFFFFFFF"},
    '{ROW_PREDICT, ALL_ONES,               6'd2,  "0"},
    '{ROW_PREDICT, ALL_ONES,               6'd36, "0"},
    '{ROW_TEXT,    ALL_ONES,               6'd10, "18446744073709551615"},
    '{ROW_TEXT,    64'd1,                  6'd2,  "1"},
    '{ROW_TEXT,    64'd35,                 6'd36, "Z"},
    '{ROW_TEXT,    64'd9,                  6'd10, "9"},
    '{ROW_TEXT,    64'd10,                 6'd11, "A"},
    '{ROW_TEXT,    64'd36,                 6'd36, "10"},
    '{ROW_BAD,     64'd0,                  6'd0,  "0"},
    '{ROW_BAD,     ALL_ONES,               6'd1,  "0"},
    '{ROW_BAD,     64'd5,                  6'd37, "0"},
    '{ROW_BAD,     ALL_ONES,               6'd63, "0"},
    '{ROW_BAD,     64'd0,                  6'd63, "0"},
    '{ROW_PREDICT, 64'h8000_0000_0000_0000, 6'd2,  "0"},
    '{ROW_PREDICT, 64'h7FFF_FFFF_FFFF_FFFF, 6'd8,  "0"},
    '{ROW_TEXT,    64'd255,                6'd16, "FF"},
    '{ROW_TEXT,    64'h1234_5678_9ABC_DEF0, 6'd16, "123456789ABCDEF0"},
    '{ROW_PREDICT, 64'hAAAA_AAAA_AAAA_AAAA, 6'd32, "0"},
    '{ROW_PREDICT, 64'h5555_5555_5555_5555, 6'd35, "0"},
    '{ROW_PREDICT, 64'd100,                6'd3,  "0"}
  };

  unsigned_to_radix_ascii_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("MISMATCH at cycle %0d, %s: got %0h, wanted %0h", cycle_cnt, what, got, want);
    mismatch_cnt++;
  endtask

  function automatic logic [7:0] digit_ascii(input logic [5:0] d);
    if (d < DECIMAL_TOP) begin
      return ASCII_ZERO + {2'b00, d};
    end
    return ASCII_A - {2'b00, DECIMAL_TOP} + {2'b00, d};
  endfunction

  // Expected characters of one conversion, most significant digit first.
  task automatic predict_conversion(input logic [63:0] value, input logic [5:0] radix);
    logic [63:0] quot;
    logic [5:0]  digits [u2ra_pkg::DIGIT_DEPTH];
    int          n;
    if (radix < RADIX_LO || radix > RADIX_HI) begin
      char_q.push_back('{ch: 8'h00, last: 1'b1, bad: 1'b1});
    end else begin
      quot = value;
      n = 0;
      do begin
        digits[n] = 6'(quot % {58'd0, radix});
        n++;
        quot = quot / {58'd0, radix};
      end while (quot != 0 && n < u2ra_pkg::DIGIT_DEPTH);
      for (int i = n - 1; i >= 0; i--) begin
        char_q.push_back('{ch: digit_ascii(digits[i]), last: (i == 0), bad: 1'b0});
      end
    end
  endtask

  // Typed-in text: nonzero bytes from the top, last flag on the final one.
  task automatic expect_text(input logic [8*TXT_BYTES-1:0] txt);
    logic [7:0] chars [$];
    logic [7:0] c;
    for (int b = TXT_BYTES - 1; b >= 0; b--) begin
      c = txt[8*b +: 8];
      if (c != 8'h00) chars.push_back(c);
    end
    foreach (chars[i]) begin
      char_q.push_back('{ch: chars[i], last: (i == chars.size() - 1), bad: 1'b0});
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_conversion(input row_kind_e kind, input logic [63:0] value,
                                 input logic [5:0] radix, input logic [8*TXT_BYTES-1:0] txt);
    int unsigned gap;
    if (!tail_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {{(u2ra_pkg::IN_TDATA_W - u2ra_pkg::IN_W){1'b0}}, radix, value};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    case (kind)
      ROW_TEXT: expect_text(txt);
      ROW_BAD:  char_q.push_back('{ch: 8'h00, last: 1'b1, bad: 1'b1});
      default:  predict_conversion(value, radix);
    endcase
  endtask

  // Receiver: random stall bursts between ready stretches.
  always @(negedge clk_i) begin
    if (tail_phase) begin
      m_axis_tready <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold--;
    end else if (m_axis_tready && $urandom_range(0, 2) == 0) begin
      m_axis_tready <= 1'b0;
      ready_hold = $urandom_range(0, 17);
    end else begin
      m_axis_tready <= 1'b1;
      ready_hold = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(0, 30);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (char_q.size() == 0) begin
        report_mismatch("character with nothing expected", m_axis_tdata, 8'h00);
      end else begin
        head_r = char_q.pop_front();
        if (m_axis_tdata !== head_r.ch) report_mismatch("digit_char", m_axis_tdata, head_r.ch);
        if (m_axis_tlast !== head_r.last) begin
          report_mismatch("last", {7'd0, m_axis_tlast}, {7'd0, head_r.last});
        end
        if (m_axis_tuser !== head_r.bad) begin
          report_mismatch("bad_radix", {7'd0, m_axis_tuser}, {7'd0, head_r.bad});
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [63:0] value;
    logic [5:0]  radix;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      send_conversion(dir_rows[i].kind, dir_rows[i].value, dir_rows[i].radix, dir_rows[i].txt);
    end

    // hold off until the pipeline has drained completely
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (char_q.size() != 0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS * 7 / 8) tail_phase = 1'b1;
      case ($urandom_range(0, 9))
        0, 1:    radix = 6'($urandom_range(0, 63));
        2: begin
          case ($urandom_range(0, 3))
            0:       radix = 6'd2;
            1:       radix = 6'd10;
            2:       radix = 6'd16;
            default: radix = 6'd36;
          endcase
        end
        default: radix = 6'($urandom_range(2, 36));
      endcase
      case ($urandom_range(0, 19))
        0:       value = 64'd0;
        1:       value = ALL_ONES;
        default: value = {$urandom, $urandom} >> $urandom_range(0, 63);
      endcase
      send_conversion(ROW_PREDICT, value, radix, '0);
    end

    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (char_q.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (char_q.size() != 0) begin
      report_mismatch("characters never produced", 8'h00, char_q[0].ch);
    end
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
